[rtl/core/mta_pkg.sv]
// shared types, constants and codes of the mesh tangent accumulator
package mta_pkg;

	localparam int VERTEX_SLOTS = 4096;
	localparam int ADDR_W = $clog2(VERTEX_SLOTS);
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 23;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_INDEX = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DET_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_FACTOR = 1'd1;

	localparam logic [15:0] DET_THRESHOLD_RST = 16'd1;
	localparam logic [22:0] FALLBACK_FACTOR_RST = 23'd100000;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [11:0]        vtx_slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} in_item_t;

	typedef struct packed {
		logic [11:0]        read_index;
		logic signed [47:0] tangent_x;
		logic signed [47:0] tangent_y;
		logic signed [47:0] tangent_z;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDOUT,
		S_VRD,
		S_DIFF,
		S_MUL,
		S_DET,
		S_FACT,
		S_DIV,
		S_DFIN,
		S_SCALE,
		S_ZFIX,
		S_ACC
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_CORNER,
		DP_TAN_RD,
		DP_OUT_LOAD,
		DP_VRD,
		DP_DIFF,
		DP_MUL,
		DP_DET,
		DP_FACT,
		DP_DIV_STEP,
		DP_DIV_FIN,
		DP_SCALE,
		DP_ZFIX,
		DP_ACC_RD,
		DP_ACC_WR
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] sel;
	} ctrl_t;

	typedef struct packed {
		logic use_div;
	} stat_t;

endpackage

[rtl/core/mta_ctrl.sv]
// sequencer of the mesh tangent accumulator
module mta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_cmd,
	input  logic          out_stall,
	input  mta_pkg::stat_t stat,
	output logic          in_stall,
	output logic          out_valid,
	output mta_pkg::ctrl_t ctrl
);
	import mta_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       count_q;
	logic             out_valid_q;
	logic             accept;

	assign in_stall = (state_q != S_IDLE) ||
		(in_cmd == CMD_READ && out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_cmd == CMD_INDEX && count_q == 2'd2) state_d = S_VRD;
				else if (accept && in_cmd == CMD_READ) state_d = S_RDOUT;
			end
			S_RDOUT: state_d = S_IDLE;
			S_VRD: if (cnt_q == CNT_W'(3)) state_d = S_DIFF;
			S_DIFF: state_d = S_MUL;
			S_MUL: if (cnt_q == CNT_W'(8)) state_d = S_DET;
			S_DET: state_d = S_FACT;
			S_FACT: state_d = stat.use_div ? S_DIV : S_SCALE;
			S_DIV: if (cnt_q == CNT_W'(48)) state_d = S_DFIN;
			S_DFIN: state_d = S_SCALE;
			S_SCALE: if (cnt_q == CNT_W'(13)) state_d = S_ZFIX;
			S_ZFIX: state_d = S_ACC;
			S_ACC: if (cnt_q == CNT_W'(5)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op = DP_NOP;
		ctrl.sel = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				ctrl.sel = CNT_W'(count_q);
				if (accept) begin
					case (in_cmd)
						CMD_LOAD: ctrl.op = DP_LOAD;
						CMD_INDEX: ctrl.op = DP_CORNER;
						CMD_READ: ctrl.op = DP_TAN_RD;
						default: ctrl.op = DP_NOP;
					endcase
				end
			end
			S_RDOUT: ctrl.op = DP_OUT_LOAD;
			S_VRD: ctrl.op = DP_VRD;
			S_DIFF: ctrl.op = DP_DIFF;
			S_MUL: ctrl.op = DP_MUL;
			S_DET: ctrl.op = DP_DET;
			S_FACT: ctrl.op = DP_FACT;
			S_DIV: ctrl.op = DP_DIV_STEP;
			S_DFIN: ctrl.op = DP_DIV_FIN;
			S_SCALE: ctrl.op = DP_SCALE;
			S_ZFIX: ctrl.op = DP_ZFIX;
			S_ACC: ctrl.op = cnt_q[0] ? DP_ACC_WR : DP_ACC_RD;
			default: ctrl.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			if (state_q == S_IDLE && accept && in_cmd == CMD_INDEX)
				count_q <= (count_q == 2'd2) ? 2'd0 : count_q + 2'd1;
			if (state_q == S_RDOUT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/mta_dp.sv]
// vertex and tangent stores, shared multiplier, divider and accumulate path
module mta_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mta_pkg::in_item_t                in_item,
	input  mta_pkg::ctrl_t                   ctrl,
	input  logic                             cfg_we,
	input  logic [mta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mta_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mta_pkg::stat_t                   stat,
	output mta_pkg::out_item_t               out_item
);
	import mta_pkg::*;

	localparam int VTX_W = 160;
	localparam int TAN_W = 144;

	function automatic logic [31:0] sub_sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) sub_sat32 = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		else sub_sat32 = d[31:0];
	endfunction

	function automatic logic [63:0] sub_sat64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] d;
		d = {a[63], a} - {b[63], b};
		if (d[64] != d[63]) sub_sat64 = d[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		else sub_sat64 = d[63:0];
	endfunction

	function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] d;
		d = {a[47], a} + {b[47], b};
		if (d[48] != d[47]) add_sat48 = d[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		else add_sat48 = d[47:0];
	endfunction

	function automatic logic [47:0] scale_fin(input logic [102:0] acc, input logic neg);
		logic [70:0] r;
		logic        big;
		r = acc[102:32];
		big = |r[70:47];
		if (neg) scale_fin = big ? {1'b1, 47'b0} : 48'(-r[47:0]);
		else scale_fin = big ? {1'b0, {47{1'b1}}} : r[47:0];
	endfunction

	logic [VTX_W-1:0]  vmem [VERTEX_SLOTS];
	logic [TAN_W-1:0]  tmem [VERTEX_SLOTS];
	logic [VTX_W-1:0]  vrd_q;
	logic [TAN_W-1:0]  trd_q;
	logic [ADDR_W-1:0] corner_q [3];
	logic [ADDR_W-1:0] rslot_q;
	logic [VTX_W-1:0]  vtx_q [3];
	logic [31:0]       e1_q [3];
	logic [31:0]       e2_q [3];
	logic [31:0]       du1_q, dv1_q, du2_q, dv2_q;
	logic [63:0]       prod_s1;
	logic [63:0]       p_q [8];
	logic [63:0]       det_q;
	logic [63:0]       n_q [3];
	logic [63:0]       mag_q [3];
	logic              neg_q [3];
	logic              use_div_q;
	logic [38:0]       factor_q;
	logic [63:0]       rem_q;
	logic [48:0]       quo_q;
	logic [102:0]      acc_q;
	logic [47:0]       t_q [3];
	out_item_t         out_q;
	logic [15:0]       thr_q;
	logic [22:0]       ff_q;

	logic [ADDR_W-1:0] slot;
	logic [ADDR_W-1:0] acc_addr;
	logic              v_we, t_we;
	logic [ADDR_W-1:0] t_waddr, t_raddr;
	logic [TAN_W-1:0]  t_wdata;
	logic [TAN_W-1:0]  t_sum;
	logic [63:0]       det_w;
	logic [63:0]       n_w [3];
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [3:0]        sk, sk_acc, sk_fin;
	logic [1:0]        jj;
	logic [102:0]      pp_ext;
	logic [64:0]       div_rs;
	logic              div_ge;

	assign slot = in_item.vtx_slot[ADDR_W-1:0];
	assign acc_addr = (ctrl.sel[2:1] == 2'd2) ? corner_q[2] :
		(ctrl.sel[2:1] == 2'd1) ? corner_q[1] : corner_q[0];
	assign stat.use_div = use_div_q;
	assign out_item = out_q;

	// memories
	assign v_we = (ctrl.op == DP_LOAD);
	always_ff @(posedge clk) begin
		if (v_we)
			vmem[slot] <= {in_item.tex_v, in_item.tex_u, in_item.pos_z,
				in_item.pos_y, in_item.pos_x};
		vrd_q <= vmem[(ctrl.sel[1:0] == 2'd2) ? corner_q[2] :
			(ctrl.sel[1:0] == 2'd1) ? corner_q[1] : corner_q[0]];
	end

	assign t_sum = {add_sat48(trd_q[143:96], t_q[2]), add_sat48(trd_q[95:48], t_q[1]),
		add_sat48(trd_q[47:0], t_q[0])};
	assign t_we = (ctrl.op == DP_LOAD) || (ctrl.op == DP_ACC_WR);
	assign t_waddr = (ctrl.op == DP_LOAD) ? slot : acc_addr;
	assign t_wdata = (ctrl.op == DP_LOAD) ? '0 : t_sum;
	assign t_raddr = (ctrl.op == DP_TAN_RD) ? slot : acc_addr;
	always_ff @(posedge clk) begin
		if (t_we) tmem[t_waddr] <= t_wdata;
		trd_q <= tmem[t_raddr];
	end

	// differences of products
	assign det_w = sub_sat64(p_q[0], p_q[1]);
	always_comb begin
		for (int c = 0; c < 3; c++) n_w[c] = sub_sat64(p_q[2 + 2 * c], p_q[3 + 2 * c]);
	end

	// shared multiplier operand select
	assign sk = ctrl.sel[3:0];
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			DP_MUL: begin
				case (ctrl.sel[2:0])
					3'd0: begin mul_a = {du1_q[31], du1_q}; mul_b = {dv2_q[31], dv2_q}; end
					3'd1: begin mul_a = {du2_q[31], du2_q}; mul_b = {dv1_q[31], dv1_q}; end
					3'd2: begin mul_a = {dv2_q[31], dv2_q}; mul_b = {e1_q[0][31], e1_q[0]}; end
					3'd3: begin mul_a = {dv1_q[31], dv1_q}; mul_b = {e2_q[0][31], e2_q[0]}; end
					3'd4: begin mul_a = {dv2_q[31], dv2_q}; mul_b = {e1_q[1][31], e1_q[1]}; end
					3'd5: begin mul_a = {dv1_q[31], dv1_q}; mul_b = {e2_q[1][31], e2_q[1]}; end
					3'd6: begin mul_a = {dv2_q[31], dv2_q}; mul_b = {e1_q[2][31], e1_q[2]}; end
					default: begin mul_a = {dv1_q[31], dv1_q}; mul_b = {e2_q[2][31], e2_q[2]}; end
				endcase
			end
			DP_SCALE: begin
				if (ctrl.sel < CNT_W'(12)) begin
					mul_a = sk[1] ? {26'b0, factor_q[38:32]} : {1'b0, factor_q[31:0]};
					case (sk[3:2])
						2'd0: mul_b = sk[0] ? {1'b0, mag_q[0][63:32]} : {1'b0, mag_q[0][31:0]};
						2'd1: mul_b = sk[0] ? {1'b0, mag_q[1][63:32]} : {1'b0, mag_q[1][31:0]};
						default: mul_b = sk[0] ? {1'b0, mag_q[2][63:32]} : {1'b0, mag_q[2][31:0]};
					endcase
				end
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// partial product alignment for the scale step
	assign sk_acc = 4'(ctrl.sel - CNT_W'(1));
	assign sk_fin = 4'(ctrl.sel - CNT_W'(2));
	assign jj = sk_acc[1:0];
	always_comb begin
		case (jj) inside
			2'd0: pp_ext = {39'b0, prod_s1};
			2'd1, 2'd2: pp_ext = {7'b0, prod_s1, 32'b0};
			default: pp_ext = {prod_s1[38:0], 64'b0};
		endcase
	end

	// restoring divide of 2^48 by det, one quotient bit a cycle
	assign div_rs = {rem_q, ctrl.sel == '0};
	assign div_ge = div_rs >= {1'b0, det_q};

	always_ff @(posedge clk) begin
		prod_s1 <= mul_p[63:0];
		case (ctrl.op)
			DP_CORNER: corner_q[ctrl.sel[1:0]] <= slot;
			DP_TAN_RD: rslot_q <= slot;
			DP_OUT_LOAD: begin
				out_q.read_index <= rslot_q;
				out_q.tangent_x <= trd_q[47:0];
				out_q.tangent_y <= trd_q[95:48];
				out_q.tangent_z <= trd_q[143:96];
			end
			DP_VRD: if (ctrl.sel != '0) vtx_q[2'(ctrl.sel - CNT_W'(1))] <= vrd_q;
			DP_DIFF: begin
				for (int c = 0; c < 3; c++) begin
					e1_q[c] <= sub_sat32(vtx_q[1][32 * c +: 32], vtx_q[0][32 * c +: 32]);
					e2_q[c] <= sub_sat32(vtx_q[2][32 * c +: 32], vtx_q[0][32 * c +: 32]);
				end
				du1_q <= sub_sat32(vtx_q[1][127:96], vtx_q[0][127:96]);
				dv1_q <= sub_sat32(vtx_q[1][159:128], vtx_q[0][159:128]);
				du2_q <= sub_sat32(vtx_q[2][127:96], vtx_q[0][127:96]);
				dv2_q <= sub_sat32(vtx_q[2][159:128], vtx_q[0][159:128]);
			end
			DP_MUL: if (ctrl.sel != '0) p_q[3'(ctrl.sel - CNT_W'(1))] <= prod_s1;
			DP_DET: begin
				det_q <= det_w;
				for (int c = 0; c < 3; c++) n_q[c] <= n_w[c];
				use_div_q <= $signed(det_w) > $signed({32'b0, thr_q, 16'b0});
			end
			DP_FACT: begin
				for (int c = 0; c < 3; c++) begin
					mag_q[c] <= n_q[c][63] ? 64'(-n_q[c]) : n_q[c];
					neg_q[c] <= n_q[c][63];
				end
				factor_q <= {ff_q, 16'b0};
				rem_q <= '0;
				quo_q <= '0;
			end
			DP_DIV_STEP: begin
				rem_q <= div_ge ? 64'(div_rs - {1'b0, det_q}) : div_rs[63:0];
				quo_q <= {quo_q[47:0], div_ge};
			end
			DP_DIV_FIN: factor_q <= (|quo_q[48:39]) ? '1 : quo_q[38:0];
			DP_SCALE: begin
				if (ctrl.sel != '0 && ctrl.sel <= CNT_W'(12))
					acc_q <= (jj == 2'd0) ? pp_ext : acc_q + pp_ext;
				if (ctrl.sel >= CNT_W'(2) && sk_fin[1:0] == 2'd3) begin
					case (sk_fin[3:2])
						2'd0: t_q[0] <= scale_fin(acc_q, neg_q[0]);
						2'd1: t_q[1] <= scale_fin(acc_q, neg_q[1]);
						default: t_q[2] <= scale_fin(acc_q, neg_q[2]);
					endcase
				end
			end
			// all-zero tangent becomes unit x
			DP_ZFIX: if (t_q[0] == '0 && t_q[1] == '0 && t_q[2] == '0) t_q[0] <= 48'd65536;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= DET_THRESHOLD_RST;
			ff_q <= FALLBACK_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DET_THRESHOLD: thr_q <= cfg_data[15:0];
				CFG_FALLBACK_FACTOR: ff_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/mesh_tangent_accumulator_unit.sv]
// top level of the mesh tangent accumulator
// takes one item per command: a load writes a vertex (position and uv in signed q16.16) into
// its slot and clears that slot's tangent sum; a triangle index that is not the third of a
// triangle is recorded without making the block busy; a read returns the slot's q32.16 tangent
// sum via the registered tangent-store read and the output register, and a next item other
// than a read may enter once the read has left its output state, while that result waits.
// the third index of a triangle keeps the block busy, passing through the bit-per-cycle
// reciprocal divider only when the uv determinant is above det_threshold; the single shared
// 33x33 multiplier forms the determinant and numerators and then the three tangent
// components, and the registered-read tangent store does a read and then a write for each
// of the three read-modify-write updates. vertex and tangent stores hold garbage until a
// load writes the slot
module mesh_tangent_accumulator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mta_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mta_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [mta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mta_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mta_pkg::*;

	// command and status between sequencer and datapath
	ctrl_t ctrl;
	stat_t stat;

	mta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_item.cmd),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ctrl      (ctrl)
	);

	mta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.ctrl      (ctrl),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_item  (out_item)
	);

	// a new result only ever follows an accepted read item
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && in_item.cmd == CMD_READ, 2))
		else $error("result without a read item");

	// the reported slot is the one the read asked for
	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_item.read_index == $past(in_item.vtx_slot, 2))
		else $error("result slot mismatch");

endmodule
